// ===== rtl/odq_pkg.sv =====
// ----------------------------------------------------------------------------
// odq_pkg
// Shared types and constants for the ordered deque with search: action
// and status codes, cell operations and the link between neighbor cells.
// ----------------------------------------------------------------------------
package odq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_FIND       = 3'd4,
        ACT_REMOVE     = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,
        OP_COMPARE   = 3'd1,
        OP_SHIFT_IN  = 3'd2,
        OP_APPEND    = 3'd3,
        OP_SHIFT_OUT = 3'd4,
        OP_DROP_LAST = 3'd5,
        OP_REMOVE    = 3'd6
    } t_cell_op;

    typedef struct packed {
        logic valid;
        logic seen;
    } t_link;

endpackage

// ===== rtl/ordered_deque_with_search_top.sv =====
// ----------------------------------------------------------------------------
// ordered_deque_with_search_top
// Bounded ordered deque of DEPTH words with push and pop at both ends,
// find and remove of the first matching word.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with i_action and i_value while busy is low; the word is
//   taken at that edge. busy stays high while the action is in flight.
//   In the compare step, during the accept cycle, every cell compares its
//   word against i_value. In the update step cells shift or load, the
//   first-match chain runs along the row of cells, and the count, status
//   and position are updated. In the gather step front and back are
//   gathered from the cells, and in the cycle after it o_done pulses with
//   o_status, o_position, o_entry_count, o_front_value and o_back_value;
//   the result is valid only in that cycle and the receiver cannot stall it.
//   A new action is not taken until the last one has been through the
//   compare, update and gather steps of the cell row. start may be raised
//   again in the cycle o_done is high.
//   Reset empties the deque (all valid bits clear, count zero) and drops
//   any action in flight.
// ----------------------------------------------------------------------------
module ordered_deque_with_search_top #(
    parameter int DEPTH      = odq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = odq_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [odq_pkg::ACTION_W-1:0]   i_action,
    input  logic signed [odq_pkg::VALUE_W-1:0] i_value,
    output logic                           o_done,
    output logic [odq_pkg::STATUS_W-1:0]   o_status,
    output logic signed [odq_pkg::POS_W-1:0] o_position,
    output logic [odq_pkg::COUNT_W-1:0]    o_entry_count,
    output logic signed [odq_pkg::VALUE_W-1:0] o_front_value,
    output logic signed [odq_pkg::VALUE_W-1:0] o_back_value
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPORT
    } t_state;

    t_state                          r_state;
    odq_pkg::t_action                r_action;
    logic [DATA_WIDTH-1:0]           r_value;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    odq_pkg::t_status                r_status;
    odq_pkg::t_status                n_status;
    logic [odq_pkg::POS_W-1:0]       r_pos;
    logic [odq_pkg::POS_W-1:0]       n_pos;
    logic                            r_done;
    logic [odq_pkg::STATUS_W-1:0]    r_o_status;
    logic [odq_pkg::POS_W-1:0]       r_o_pos;
    logic [odq_pkg::COUNT_W-1:0]     r_o_count;
    logic [odq_pkg::VALUE_W-1:0]     r_o_front;
    logic [odq_pkg::VALUE_W-1:0]     r_o_back;

    logic                            w_accept;
    logic [DATA_WIDTH-1:0]           w_in_value;
    logic [DATA_WIDTH-1:0]           w_cell_value;
    odq_pkg::t_cell_op               w_op;
    logic                            w_full;
    logic                            w_empty;
    logic                            w_hit;
    logic [IW-1:0]                   w_hit_idx;
    logic [DATA_WIDTH-1:0]           w_back;
    logic [DATA_WIDTH-1:0]           w_front;

    odq_pkg::t_link                  w_link   [DEPTH];
    logic [DATA_WIDTH-1:0]           w_data   [DEPTH];
    odq_pkg::t_link                  w_left   [DEPTH];
    logic [DATA_WIDTH-1:0]           w_ldata  [DEPTH];
    logic                            w_rvalid [DEPTH];
    logic [DATA_WIDTH-1:0]           w_rdata  [DEPTH];

    logic [DATA_WIDTH+odq_pkg::VALUE_W-1:0] w_in_ext;
    logic [IW+odq_pkg::POS_W-1:0]           w_pos_ext;
    logic [CW+odq_pkg::COUNT_W-1:0]         w_cnt_ext;
    logic [DATA_WIDTH+odq_pkg::VALUE_W-1:0] w_front_ext;
    logic [DATA_WIDTH+odq_pkg::VALUE_W-1:0] w_back_ext;

    assign w_accept     = start && !busy;
    assign busy         = (r_state != S_IDLE);
    assign w_in_ext     = {{DATA_WIDTH{1'b0}}, i_value};
    assign w_in_value   = w_in_ext[DATA_WIDTH-1:0];
    assign w_cell_value = (r_state == S_IDLE) ? w_in_value : r_value;
    assign w_full       = (r_count == CW'(DEPTH));
    assign w_empty      = (r_count == '0);
    assign w_hit        = w_link[DEPTH-1].seen;

    always_comb begin
        w_op = odq_pkg::OP_HOLD;
        if (r_state == S_IDLE) begin
            if (w_accept) begin
                w_op = odq_pkg::OP_COMPARE;
            end
        end else if (r_state == S_EXEC) begin
            case (r_action)
                odq_pkg::ACT_PUSH_FRONT: begin
                    if (!w_full) w_op = odq_pkg::OP_SHIFT_IN;
                end
                odq_pkg::ACT_PUSH_BACK: begin
                    if (!w_full) w_op = odq_pkg::OP_APPEND;
                end
                odq_pkg::ACT_POP_FRONT: begin
                    if (!w_empty) w_op = odq_pkg::OP_SHIFT_OUT;
                end
                odq_pkg::ACT_POP_BACK: begin
                    if (!w_empty) w_op = odq_pkg::OP_DROP_LAST;
                end
                odq_pkg::ACT_REMOVE: begin
                    w_op = odq_pkg::OP_REMOVE;
                end
                default: begin
                    w_op = odq_pkg::OP_HOLD;
                end
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g]  = '{valid: 1'b1, seen: 1'b0};
            assign w_ldata[g] = w_cell_value;
        end else begin : g_body
            assign w_left[g]  = w_link[g-1];
            assign w_ldata[g] = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_rvalid[g] = 1'b0;
            assign w_rdata[g]  = '0;
        end else begin : g_inner
            assign w_rvalid[g] = w_link[g+1].valid;
            assign w_rdata[g]  = w_data[g+1];
        end

        odq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_value      (w_cell_value),
            .i_left       (w_left[g]),
            .i_left_data  (w_ldata[g]),
            .i_right_valid(w_rvalid[g]),
            .i_right_data (w_rdata[g]),
            .o_link       (w_link[g]),
            .o_data       (w_data[g])
        );
    end

    always_comb begin
        w_hit_idx = '0;
        w_back    = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_link[i].seen && !w_left[i].seen) begin
                w_hit_idx = w_hit_idx | IW'(i);
            end
            if (w_link[i].valid && !w_rvalid[i]) begin
                w_back = w_back | w_data[i];
            end
        end
    end

    assign w_front     = w_link[0].valid ? w_data[0] : '0;
    assign w_pos_ext   = {{odq_pkg::POS_W{1'b0}}, w_hit_idx};
    assign w_cnt_ext   = {{odq_pkg::COUNT_W{1'b0}}, r_count};
    assign w_front_ext = {{odq_pkg::VALUE_W{1'b0}}, w_front};
    assign w_back_ext  = {{odq_pkg::VALUE_W{1'b0}}, w_back};

    always_comb begin
        n_count  = r_count;
        n_status = odq_pkg::ST_OK;
        n_pos    = '1;
        case (r_action)
            odq_pkg::ACT_PUSH_FRONT, odq_pkg::ACT_PUSH_BACK: begin
                if (w_full) begin
                    n_status = odq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            odq_pkg::ACT_POP_FRONT, odq_pkg::ACT_POP_BACK: begin
                if (w_empty) begin
                    n_status = odq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            odq_pkg::ACT_FIND: begin
                if (w_hit) begin
                    n_pos = w_pos_ext[odq_pkg::POS_W-1:0];
                end else begin
                    n_status = odq_pkg::ST_NOT_FOUND;
                end
            end
            odq_pkg::ACT_REMOVE: begin
                if (w_hit) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = odq_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_action <= odq_pkg::ACT_FIND;
            r_status <= odq_pkg::ST_OK;
            r_pos    <= '1;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_action <= odq_pkg::t_action'(i_action);
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_count  <= n_count;
                    r_status <= n_status;
                    r_pos    <= n_pos;
                    r_state  <= S_REPORT;
                end
                S_REPORT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= w_in_value;
        end
        if (r_state == S_REPORT) begin
            r_o_status <= r_status;
            r_o_pos    <= r_pos;
            r_o_count  <= w_cnt_ext[odq_pkg::COUNT_W-1:0];
            r_o_front  <= w_front_ext[odq_pkg::VALUE_W-1:0];
            r_o_back   <= w_back_ext[odq_pkg::VALUE_W-1:0];
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_o_status;
    assign o_position    = r_o_pos;
    assign o_entry_count = r_o_count;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;

endmodule

// ===== rtl/odq_cell.sv =====
// ----------------------------------------------------------------------------
// odq_cell
// One deque slot: holds a word and its valid bit, compares against the
// search word, and takes a word from its left or right neighbor on shifts.
// ----------------------------------------------------------------------------
module odq_cell #(
    parameter int DATA_WIDTH = odq_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  odq_pkg::t_cell_op     i_op,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  odq_pkg::t_link        i_left,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic                  i_right_valid,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    output odq_pkg::t_link        o_link,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic                  r_valid;
    logic                  r_match;
    logic [DATA_WIDTH-1:0] r_data;
    logic                  n_valid;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_data_en;

    always_comb begin
        n_valid   = r_valid;
        n_data    = r_data;
        w_data_en = 1'b0;
        case (i_op)
            odq_pkg::OP_SHIFT_IN: begin
                n_valid   = i_left.valid;
                n_data    = i_left_data;
                w_data_en = 1'b1;
            end
            odq_pkg::OP_APPEND: begin
                if (!r_valid && i_left.valid) begin
                    n_valid   = 1'b1;
                    n_data    = i_value;
                    w_data_en = 1'b1;
                end
            end
            odq_pkg::OP_SHIFT_OUT: begin
                n_valid   = i_right_valid;
                n_data    = i_right_data;
                w_data_en = 1'b1;
            end
            odq_pkg::OP_DROP_LAST: begin
                if (!i_right_valid) begin
                    n_valid = 1'b0;
                end
            end
            odq_pkg::OP_REMOVE: begin
                if (i_left.seen || r_match) begin
                    n_valid   = i_right_valid;
                    n_data    = i_right_data;
                    w_data_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_op == odq_pkg::OP_COMPARE) begin
                r_match <= r_valid && (r_data == i_value);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data_en) begin
            r_data <= n_data;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.seen  = i_left.seen | r_match;
    assign o_data       = r_data;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for ordered_deque_with_search_top. A scoreboard keeps its own
// copy of the list, works out the expected status, position, count, front
// and back for every accepted word, and checks each o_done result against
// it in order. Directed words cover empty and full lists, the extreme
// values, unused action codes and a match at the back end. Random words then
// swing the list between empty and full, with idle bursts on the sender
// side.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH     = odq_pkg::DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_WORDS   = 1000;
    localparam int QUIET_TAIL     = 150;
    localparam logic [odq_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [odq_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam logic signed [odq_pkg::POS_W-1:0] NO_POS = '1;
    localparam logic signed [odq_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [odq_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [odq_pkg::STATUS_W-1:0]       status;
        logic signed [odq_pkg::POS_W-1:0]   position;
        logic [odq_pkg::COUNT_W-1:0]        count;
        logic signed [odq_pkg::VALUE_W-1:0] front;
        logic signed [odq_pkg::VALUE_W-1:0] back;
    } t_deque_result;

    class odq_scoreboard;
        logic signed [odq_pkg::VALUE_W-1:0] shadow_list[$];
        t_deque_result                      pending_results[$];
        int errors;
        int words;
        int checked;
        int full_hits;
        int empty_hits;
        int match_hits;

        function void note_word(logic [odq_pkg::ACTION_W-1:0] action,
                                logic signed [odq_pkg::VALUE_W-1:0] value);
            t_deque_result r;
            int hit;
            r.status   = odq_pkg::ST_OK;
            r.position = NO_POS;
            hit = -1;
            for (int i = 0; i < shadow_list.size(); i++) begin
                if (hit < 0 && shadow_list[i] == value) begin
                    hit = i;
                end
            end
            case (action)
                odq_pkg::ACT_PUSH_FRONT, odq_pkg::ACT_PUSH_BACK: begin
                    if (shadow_list.size() >= LIST_DEPTH) begin
                        r.status = odq_pkg::ST_FULL;
                    end else if (action == odq_pkg::ACT_PUSH_FRONT) begin
                        shadow_list.insert(0, value);
                    end else begin
                        shadow_list.insert(shadow_list.size(), value);
                    end
                end
                odq_pkg::ACT_POP_FRONT, odq_pkg::ACT_POP_BACK: begin
                    if (shadow_list.size() == 0) begin
                        r.status = odq_pkg::ST_EMPTY;
                    end else if (action == odq_pkg::ACT_POP_FRONT) begin
                        shadow_list.delete(0);
                    end else begin
                        shadow_list.delete(shadow_list.size() - 1);
                    end
                end
                odq_pkg::ACT_FIND, odq_pkg::ACT_REMOVE: begin
                    if (hit < 0) begin
                        r.status = odq_pkg::ST_NOT_FOUND;
                    end else if (action == odq_pkg::ACT_FIND) begin
                        r.position = odq_pkg::POS_W'(hit);
                    end else begin
                        shadow_list.delete(hit);
                    end
                end
                default: begin
                end
            endcase
            r.count = odq_pkg::COUNT_W'(shadow_list.size());
            r.front = (shadow_list.size() == 0) ? '0 : shadow_list[0];
            r.back  = (shadow_list.size() == 0) ? '0 : shadow_list[shadow_list.size() - 1];
            if (r.status == odq_pkg::ST_FULL) full_hits++;
            if (r.status == odq_pkg::ST_EMPTY) empty_hits++;
            if ((action == odq_pkg::ACT_FIND || action == odq_pkg::ACT_REMOVE) && hit >= 0)
                match_hits++;
            pending_results.insert(pending_results.size(), r);
            words++;
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [odq_pkg::STATUS_W-1:0] status,
                                   logic signed [odq_pkg::POS_W-1:0] position,
                                   logic [odq_pkg::COUNT_W-1:0] count,
                                   logic signed [odq_pkg::VALUE_W-1:0] front,
                                   logic signed [odq_pkg::VALUE_W-1:0] back);
            t_deque_result e;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with no word outstanding, expected none actual status %0h",
                         $time, status);
                return;
            end
            e = pending_results[0];
            pending_results.delete(0);
            checked++;
            compare_field("status", e.status, status);
            compare_field("position", e.position, position);
            compare_field("entry_count", e.count, count);
            compare_field("front_value", e.front, front);
            compare_field("back_value", e.back, back);
        endfunction
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic [odq_pkg::ACTION_W-1:0]         i_action = '0;
    logic signed [odq_pkg::VALUE_W-1:0]   i_value = '0;
    logic                                 o_done;
    logic [odq_pkg::STATUS_W-1:0]         o_status;
    logic signed [odq_pkg::POS_W-1:0]     o_position;
    logic [odq_pkg::COUNT_W-1:0]          o_entry_count;
    logic signed [odq_pkg::VALUE_W-1:0]   o_front_value;
    logic signed [odq_pkg::VALUE_W-1:0]   o_back_value;

    odq_scoreboard scb = new();
    int stall_count = 0;

    ordered_deque_with_search_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && busy === 1'b0) begin
            scb.note_word(i_action, i_value);
        end
        if (i_rst_n && o_done === 1'b1) begin
            scb.check_result(o_status, o_position, o_entry_count, o_front_value, o_back_value);
        end
        if ((i_rst_n && start && busy === 1'b0) || o_done === 1'b1) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", stall_count);
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic send_word(logic [odq_pkg::ACTION_W-1:0] action,
                             logic signed [odq_pkg::VALUE_W-1:0] value);
        i_action <= action;
        i_value  <= value;
        start    <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (scb.pending_results.size() != 0);
    endtask

    initial begin
        int push_cut;
        int pop_cut;
        int roll;
        int vr;
        logic [odq_pkg::ACTION_W-1:0] act;
        logic signed [odq_pkg::VALUE_W-1:0] val;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, unused codes
        send_word(odq_pkg::ACT_POP_FRONT, 32'sd7);
        send_word(odq_pkg::ACT_POP_BACK, -32'sd1);
        send_word(odq_pkg::ACT_FIND, 32'sd0);
        send_word(odq_pkg::ACT_REMOVE, VAL_MIN);
        send_word(ACT_SPARE_LO, VAL_MAX);
        send_word(ACT_SPARE_HI, 32'sd3);
        // fill to full with the extreme values
        send_word(odq_pkg::ACT_PUSH_FRONT, VAL_MIN);
        send_word(odq_pkg::ACT_PUSH_FRONT, -32'sd1);
        send_word(odq_pkg::ACT_PUSH_BACK, 32'sd0);
        for (int i = 0; i < 12; i++) begin
            send_word(i[0] ? odq_pkg::ACT_PUSH_BACK : odq_pkg::ACT_PUSH_FRONT,
                      odq_pkg::VALUE_W'($urandom_range(0, 3)));
        end
        send_word(odq_pkg::ACT_PUSH_BACK, VAL_MAX);
        send_word(odq_pkg::ACT_PUSH_FRONT, 32'sd42);
        send_word(odq_pkg::ACT_PUSH_BACK, 32'sd42);
        send_word(odq_pkg::ACT_FIND, VAL_MAX);
        send_word(odq_pkg::ACT_REMOVE, VAL_MIN);
        wait_drained();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // swing between filling, draining and a balanced mix
            case ((n / 60) % 3)
                0: begin push_cut = 55; pop_cut = 75; end
                1: begin push_cut = 20; pop_cut = 65; end
                default: begin push_cut = 35; pop_cut = 60; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < push_cut) begin
                act = $urandom_range(0, 1) ? odq_pkg::ACT_PUSH_BACK : odq_pkg::ACT_PUSH_FRONT;
            end else if (roll < pop_cut) begin
                act = $urandom_range(0, 1) ? odq_pkg::ACT_POP_BACK : odq_pkg::ACT_POP_FRONT;
            end else if (roll < pop_cut + 16) begin
                act = odq_pkg::ACT_FIND;
            end else if (roll < 97) begin
                act = odq_pkg::ACT_REMOVE;
            end else begin
                act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
            end
            vr = $urandom_range(0, 9);
            if (vr < 6) begin
                val = odq_pkg::VALUE_W'($urandom_range(0, 7)) - 32'sd3;
            end else if (vr == 6) begin
                val = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            end else begin
                val = $urandom;
            end
            send_word(act, val);
            if (n == RANDOM_WORDS / 2) begin
                wait_drained();
            end else if (n < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                idle_cycles($urandom_range(1, 14));
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("covered %0d words, %0d results checked", scb.words, scb.checked);
        $display("full pushes %0d, empty pops %0d, find/remove matches %0d",
                 scb.full_hits, scb.empty_hits, scb.match_hits);
        if (scb.errors == 0 && scb.pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
